### rtl/levelset_speed_update_assert.svh
// Assertion macros for the level set update port checker
`ifndef LEVELSET_SPEED_UPDATE_ASSERT_SVH
`define LEVELSET_SPEED_UPDATE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high
`define LSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// Next-cycle implication, ignored while reset is high
`define LSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

// Next-cycle implication that also holds through reset
`define LSU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

### rtl/lsu_pkg.sv
// Types, constants and fixed point helpers for the level set update block
`default_nettype none
package lsu_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 34;

   localparam logic signed [63:0] MAX32 = 64'sd2147483647;
   localparam logic signed [63:0] MIN32 = -64'sd2147483648;

   typedef enum logic [1:0] {
      CSR_ADVECTION = 2'd0,
      CSR_INFLATION = 2'd1,
      CSR_CURVATURE = 2'd2,
      CSR_TIME_STEP = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] level_value;
      logic signed [31:0] grad_x_central;
      logic signed [31:0] grad_y_central;
      logic signed [31:0] edge_grad_x;
      logic signed [31:0] edge_grad_y;
      logic signed [31:0] inflation_map;
      logic signed [31:0] flux;
      logic signed [31:0] curvature_map;
      logic signed [31:0] mean_curvature;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_level_value;
      logic               saturated;
   } rsp_type;

   // Per-pixel data that rides alongside the root and divide pipes
   typedef struct packed {
      logic signed [31:0] lvl;
      logic signed [31:0] inf;
      logic signed [31:0] crv;
      logic [63:0]        dmag;
      logic               neg;
      logic               zero;
      logic               sat;
   } side_type;

   typedef struct packed {
      logic signed [31:0] val;
      logic               sat;
   } scaled_type;

   // Clamp a wide signed value to 32 bits
   function automatic scaled_type clamp32(input logic signed [63:0] v);
      scaled_type r;
      if (v > MAX32) begin
         r.val = 32'sh7FFFFFFF;
         r.sat = 1'b1;
      end else if (v < MIN32) begin
         r.val = 32'sh80000000;
         r.sat = 1'b1;
      end else begin
         r.val = v[31:0];
         r.sat = 1'b0;
      end
      return r;
   endfunction

   // Rescale a full product: floor shift by the fraction bits, then clamp
   function automatic scaled_type mul_scale(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> FRAC_BITS;
      return clamp32(s);
   endfunction

endpackage
`default_nettype wire

### rtl/levelset_speed_update.sv
// Level set update top level: speed terms, root and divide pipes, time step and output register
//
// One pixel word enters per clock and one result word leaves per clock for as
// long as the result side keeps stall low; a word appears on rsp_valid once it
// has passed the input stages, the 32-stage square root pipe, the 34-stage
// divider for the normalised advection term and the output stages. The whole
// pipeline holds while the output word is stalled, so req_stall follows
// rsp_stall when a result is waiting. The user must write registers through
// csr_we only while no word is in flight; the block does not enforce this.
`default_nettype none
module levelset_speed_update import lsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   logic en;

   logic signed [31:0] adv_w_ff, inf_w_ff, crv_w_ff, tstep_ff;

   logic               v1_ff;
   req_type            d1_ff;
   logic               v2_ff;
   logic signed [63:0] pdx2_ff, pdy2_ff, pgx2_ff, pgy2_ff, pinf2_ff, pk2_ff;
   logic signed [31:0] lvl2_ff, fl2_ff;
   logic               v3_ff;
   logic [63:0]        sq3_ff, dmag3_ff;
   logic               neg3_ff, zero3_ff, sat3_ff;
   logic signed [31:0] inf3_ff, k3_ff, lvl3_ff, fl3_ff;
   logic               v4_ff;
   logic signed [63:0] pcrv4_ff;
   logic [63:0]        sq4_ff, dmag4_ff;
   logic               neg4_ff, zero4_ff, sat4_ff;
   logic signed [31:0] inf4_ff, lvl4_ff;
   logic               v5_ff;
   logic [63:0]        sq5_ff;
   side_type           side5_ff;

   logic               sq_valid;
   logic [31:0]        sq_root;
   side_type           sq_side;
   logic               dv_valid;
   logic [32:0]        dv_quo;
   logic               dv_big;
   side_type           dv_side;

   logic               va_ff;
   logic signed [31:0] adva_ff;
   side_type           sidea_ff;
   logic               vb_ff, satb_ff;
   logic signed [63:0] pa_ff, pb_ff, pc_ff;
   logic signed [31:0] lvlb_ff;
   logic               vc_ff, satc_ff;
   logic signed [31:0] ac_ff, bc_ff, cc_ff, lvlc_ff;
   logic               vd_ff, satd_ff;
   logic signed [31:0] speed_ff, lvld_ff;
   logic               ve_ff, sate_ff;
   logic signed [63:0] pdelta_ff;
   logic signed [31:0] lvle_ff;
   logic               vf_ff, satf_ff;
   logic signed [31:0] delta_ff, lvlf_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // Stage logic
   logic signed [64:0] dot3_in;
   scaled_type         inf3_in, k3_in, crv5_in, a_in, b_in, c_in, speed_in, delta_in, res_in;
   logic signed [31:0] adv_in;
   logic               adv_sat_in;
   side_type           sidea_in;
   logic signed [63:0] speed_sum, res_sum;

   // Hold everything while the output word waits
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         adv_w_ff <= '0;
         inf_w_ff <= '0;
         crv_w_ff <= '0;
         tstep_ff <= 32'sd1 <<< FRAC_BITS;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ADVECTION: adv_w_ff <= csr_wdata;
            CSR_INFLATION: inf_w_ff <= csr_wdata;
            CSR_CURVATURE: crv_w_ff <= csr_wdata;
            CSR_TIME_STEP: tstep_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Combinational pieces of the early and late stages
   always_comb begin
      dot3_in  = {pgx2_ff[63], pgx2_ff} + {pgy2_ff[63], pgy2_ff};
      inf3_in  = mul_scale(pinf2_ff);
      k3_in    = mul_scale(pk2_ff);
      crv5_in  = mul_scale(pcrv4_ff);
      // Signed, saturated quotient of the advection term
      adv_in     = '0;
      adv_sat_in = 1'b0;
      if (dv_side.zero) begin
         adv_in = '0;
      end else if (dv_big) begin
         adv_sat_in = 1'b1;
         adv_in     = dv_side.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else if (dv_side.neg) begin
         if (dv_quo > 33'h080000000) begin
            adv_sat_in = 1'b1;
            adv_in     = 32'sh80000000;
         end else begin
            adv_in = 32'(-$signed({1'b0, dv_quo}));
         end
      end else begin
         if (dv_quo > 33'h07FFFFFFF) begin
            adv_sat_in = 1'b1;
            adv_in     = 32'sh7FFFFFFF;
         end else begin
            adv_in = dv_quo[31:0];
         end
      end
      // Fold the quotient clamp into the side data
      sidea_in     = dv_side;
      sidea_in.sat = dv_side.sat || (adv_sat_in && !dv_side.zero);
      a_in      = mul_scale(pa_ff);
      b_in      = mul_scale(pb_ff);
      c_in      = mul_scale(pc_ff);
      speed_sum = 64'(ac_ff) - 64'(bc_ff) + 64'(cc_ff);
      speed_in  = clamp32(speed_sum);
      delta_in  = mul_scale(pdelta_ff);
      res_sum   = 64'(lvlf_ff) + 64'(delta_ff);
      res_in    = clamp32(res_sum);
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         ve_ff        <= 1'b0;
         vf_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         va_ff        <= dv_valid;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vd_ff        <= vc_ff;
         ve_ff        <= vd_ff;
         vf_ff        <= ve_ff;
         rsp_valid_ff <= vf_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         // Input word
         d1_ff <= req_data;
         // Raw products
         pdx2_ff  <= d1_ff.grad_x_central * d1_ff.grad_x_central;
         pdy2_ff  <= d1_ff.grad_y_central * d1_ff.grad_y_central;
         pgx2_ff  <= d1_ff.edge_grad_x * d1_ff.grad_x_central;
         pgy2_ff  <= d1_ff.edge_grad_y * d1_ff.grad_y_central;
         pinf2_ff <= d1_ff.inflation_map * d1_ff.flux;
         pk2_ff   <= d1_ff.curvature_map * d1_ff.mean_curvature;
         lvl2_ff  <= d1_ff.level_value;
         fl2_ff   <= d1_ff.flux;
         // Squared magnitude, dot product sign and magnitude, map terms
         sq3_ff   <= 64'(pdx2_ff) + 64'(pdy2_ff);
         neg3_ff  <= dot3_in[64];
         dmag3_ff <= dot3_in[64] ? 64'(-dot3_in) : dot3_in[63:0];
         zero3_ff <= (pdx2_ff == '0) && (pdy2_ff == '0);
         inf3_ff  <= inf3_in.val;
         k3_ff    <= k3_in.val;
         sat3_ff  <= inf3_in.sat || k3_in.sat;
         lvl3_ff  <= lvl2_ff;
         fl3_ff   <= fl2_ff;
         // Curvature product
         pcrv4_ff <= k3_ff * fl3_ff;
         sq4_ff   <= sq3_ff;
         dmag4_ff <= dmag3_ff;
         neg4_ff  <= neg3_ff;
         zero4_ff <= zero3_ff;
         inf4_ff  <= inf3_ff;
         sat4_ff  <= sat3_ff;
         lvl4_ff  <= lvl3_ff;
         // Gather the data that rides along the root and divide pipes
         sq5_ff        <= sq4_ff;
         side5_ff.lvl  <= lvl4_ff;
         side5_ff.inf  <= inf4_ff;
         side5_ff.crv  <= crv5_in.val;
         side5_ff.dmag <= dmag4_ff;
         side5_ff.neg  <= neg4_ff;
         side5_ff.zero <= zero4_ff;
         side5_ff.sat  <= sat4_ff || crv5_in.sat;
         // Advection quotient
         adva_ff  <= adv_in;
         sidea_ff <= sidea_in;
         // Weighted terms
         pa_ff   <= adv_w_ff * adva_ff;
         pb_ff   <= inf_w_ff * sidea_ff.inf;
         pc_ff   <= crv_w_ff * sidea_ff.crv;
         lvlb_ff <= sidea_ff.lvl;
         satb_ff <= sidea_ff.sat;
         ac_ff   <= a_in.val;
         bc_ff   <= b_in.val;
         cc_ff   <= c_in.val;
         lvlc_ff <= lvlb_ff;
         satc_ff <= satb_ff || a_in.sat || b_in.sat || c_in.sat;
         // Speed
         speed_ff <= speed_in.val;
         lvld_ff  <= lvlc_ff;
         satd_ff  <= satc_ff || speed_in.sat;
         // Time step
         pdelta_ff <= tstep_ff * speed_ff;
         lvle_ff   <= lvld_ff;
         sate_ff   <= satd_ff;
         delta_ff  <= delta_in.val;
         lvlf_ff   <= lvle_ff;
         satf_ff   <= sate_ff || delta_in.sat;
         // Output word
         rsp_data_ff.new_level_value <= res_in.val;
         rsp_data_ff.saturated       <= satf_ff || res_in.sat;
      end
   end

   lsu_sqrt_pipe u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .in_valid    (v5_ff),
      .in_radicand (sq5_ff),
      .in_side     (side5_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   lsu_div_pipe u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (sq_valid),
      .in_divisor (sq_root),
      .in_side    (sq_side),
      .out_valid  (dv_valid),
      .out_quo    (dv_quo),
      .out_big    (dv_big),
      .out_side   (dv_side)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/lsu_sqrt_pipe.sv
// Integer square root, one result bit per pipeline stage
`default_nettype none
module lsu_sqrt_pipe import lsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [63:0] in_radicand,
   input  wire side_type    in_side,
   output logic             out_valid,
   output logic [31:0]      out_root,
   output side_type         out_side
);

   logic        valid_ff [SQRT_STAGES];
   logic [33:0] rem_ff   [SQRT_STAGES];
   logic [31:0] root_ff  [SQRT_STAGES];
   logic [63:0] rad_ff   [SQRT_STAGES];
   side_type    side_ff  [SQRT_STAGES];

   logic        valid_in [SQRT_STAGES];
   logic [33:0] rem_in   [SQRT_STAGES];
   logic [31:0] root_in  [SQRT_STAGES];
   logic [63:0] rad_in   [SQRT_STAGES];
   side_type    side_in  [SQRT_STAGES];

   logic [33:0] src_rem  [SQRT_STAGES];
   logic [31:0] src_root [SQRT_STAGES];
   logic [63:0] src_rad  [SQRT_STAGES];
   logic [33:0] cand     [SQRT_STAGES];
   logic [33:0] trial    [SQRT_STAGES];

   // Pick each stage's source: the input for the first, the previous stage otherwise
   always_comb begin
      valid_in[0] = in_valid;
      src_rem[0]  = '0;
      src_root[0] = '0;
      src_rad[0]  = in_radicand;
      side_in[0]  = in_side;
      for (int i = 1; i < SQRT_STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
         src_rem[i]  = rem_ff[i-1];
         src_root[i] = root_ff[i-1];
         src_rad[i]  = rad_ff[i-1];
         side_in[i]  = side_ff[i-1];
      end
   end

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      for (int i = 0; i < SQRT_STAGES; i++) begin
         cand[i]  = {src_rem[i][31:0], src_rad[i][63:62]};
         trial[i] = {src_root[i], 2'b01};
         if (cand[i] >= trial[i]) begin
            rem_in[i]  = cand[i] - trial[i];
            root_in[i] = {src_root[i][30:0], 1'b1};
         end else begin
            rem_in[i]  = cand[i];
            root_in[i] = {src_root[i][30:0], 1'b0};
         end
         rad_in[i] = {src_rad[i][61:0], 2'b00};
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_STAGES; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < SQRT_STAGES; i++) valid_ff[i] <= valid_in[i];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SQRT_STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            rad_ff[i]  <= rad_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_root  = root_ff[SQRT_STAGES-1];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule
`default_nettype wire

### rtl/lsu_div_pipe.sv
// Restoring divide of the dot product magnitude by the gradient magnitude, one bit a stage after the first
`default_nettype none
module lsu_div_pipe import lsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        en,
   input  wire logic        in_valid,
   input  wire logic [31:0] in_divisor,
   input  wire side_type    in_side,
   output logic             out_valid,
   output logic [32:0]      out_quo,
   output logic             out_big,
   output side_type         out_side
);

   logic        valid_ff [DIV_STAGES];
   logic [31:0] rem_ff   [DIV_STAGES];
   logic [32:0] quo_ff   [DIV_STAGES];
   logic [32:0] low_ff   [DIV_STAGES];
   logic [31:0] div_ff   [DIV_STAGES];
   logic        big_ff   [DIV_STAGES];
   side_type    side_ff  [DIV_STAGES];

   logic        valid_in [DIV_STAGES];
   logic [31:0] rem_in   [DIV_STAGES];
   logic [32:0] quo_in   [DIV_STAGES];
   logic [32:0] low_in   [DIV_STAGES];
   logic [31:0] div_in   [DIV_STAGES];
   logic        big_in   [DIV_STAGES];
   side_type    side_in  [DIV_STAGES];
   logic [32:0] cand     [DIV_STAGES];

   always_comb begin
      // First stage: flag quotients of 2^33 or more, load the top dividend bits
      valid_in[0] = in_valid;
      big_in[0]   = {1'b0, in_side.dmag[63:33]} >= in_divisor;
      rem_in[0]   = {1'b0, in_side.dmag[63:33]};
      low_in[0]   = in_side.dmag[32:0];
      quo_in[0]   = '0;
      div_in[0]   = in_divisor;
      side_in[0]  = in_side;
      cand[0]     = '0;
      // Later stages: one quotient bit each
      for (int i = 1; i < DIV_STAGES; i++) begin
         valid_in[i] = valid_ff[i-1];
         big_in[i]   = big_ff[i-1];
         div_in[i]   = div_ff[i-1];
         side_in[i]  = side_ff[i-1];
         cand[i]     = {rem_ff[i-1], low_ff[i-1][32]};
         low_in[i]   = {low_ff[i-1][31:0], 1'b0};
         if (cand[i] >= {1'b0, div_ff[i-1]}) begin
            rem_in[i] = 32'(cand[i] - {1'b0, div_ff[i-1]});
            quo_in[i] = {quo_ff[i-1][31:0], 1'b1};
         end else begin
            rem_in[i] = cand[i][31:0];
            quo_in[i] = {quo_ff[i-1][31:0], 1'b0};
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_STAGES; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) valid_ff[i] <= valid_in[i];
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i]  <= rem_in[i];
            quo_ff[i]  <= quo_in[i];
            low_ff[i]  <= low_in[i];
            div_ff[i]  <= div_in[i];
            big_ff[i]  <= big_in[i];
            side_ff[i] <= side_in[i];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quo   = quo_ff[DIV_STAGES-1];
   assign out_big   = big_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/lsu_port_checker.sv
// Port-level assertions for the level set update block, bound to the top level
`default_nettype none
`include "levelset_speed_update_assert.svh"
module lsu_port_checker import lsu_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // Hold a stalled word
   `LSU_ASSERT_NEXT(a_rsp_valid_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `LSU_ASSERT_NEXT(a_rsp_data_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   // Drop all results after reset
   `LSU_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   // Stall input only behind a stalled output word
   `LSU_ASSERT_IMPLY(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

endmodule

bind levelset_speed_update lsu_port_checker u_port_checker (.*);
`default_nettype wire

### tb/sv/levelset_speed_update_checker.sv
// Checker for the level set update block: tracks registers, predicts results and compares words
module levelset_speed_update_checker import lsu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending_count
);

   logic signed [31:0] adv_weight;
   logic signed [31:0] inf_weight;
   logic signed [31:0] crv_weight;
   logic signed [31:0] step_size;
   rsp_type            pending_levels[$];

   // Clamp a wide value to 32 bits, flagging any clamp
   function automatic logic signed [63:0] clip32(input logic signed [63:0] v, inout bit sat);
      if (v > MAX32) begin
         sat = 1'b1;
         return MAX32;
      end
      if (v < MIN32) begin
         sat = 1'b1;
         return MIN32;
      end
      return v;
   endfunction

   // Fixed point product, floor of the shifted full product
   function automatic logic signed [63:0] fix_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b, inout bit sat);
      logic signed [63:0] p;
      p = a * b;
      return clip32(p >>> FRAC_BITS, sat);
   endfunction

   // Floor square root of a 64-bit unsigned value
   function automatic logic [63:0] root_floor(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bitv;
      n    = n_in;
      res  = '0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Edge gradient projected on the normalised level set gradient
   function automatic logic signed [63:0] advect_term(input logic signed [63:0] gx,
         input logic signed [63:0] gy, input logic signed [63:0] dx,
         input logic signed [63:0] dy, inout bit sat);
      logic [63:0]        sq;
      logic [63:0]        mag;
      logic [63:0]        s;
      logic [63:0]        dmag;
      logic [63:0]        q;
      logic signed [63:0] p1;
      logic signed [63:0] p2;
      bit                 neg;
      sq = 64'(dx * dx) + 64'(dy * dy);
      if (sq == 0) return 0;
      mag = root_floor(sq);
      p1  = gx * dx;
      p2  = gy * dy;
      s   = 64'(p1) + 64'(p2);
      if (p1 >= 0 && p2 >= 0) begin
         neg  = 1'b0;
         dmag = s;
      end else if (p1 < 0 && p2 < 0) begin
         neg  = 1'b1;
         dmag = 64'd0 - s;
      end else begin
         neg  = s[63];
         dmag = neg ? 64'd0 - s : s;
      end
      q = dmag / mag;
      if (neg) begin
         if (q > 64'h80000000) begin
            sat = 1'b1;
            return MIN32;
         end
         return -$signed(q);
      end
      if (q > 64'h7FFFFFFF) begin
         sat = 1'b1;
         return MAX32;
      end
      return $signed(q);
   endfunction

   // Expected updated level for one pixel under the current registers
   function automatic rsp_type update_pixel(input req_type px);
      rsp_type            r;
      bit                 sat;
      logic signed [63:0] adv, inf, crv, a, b, c, speed, delta, res;
      sat   = 1'b0;
      adv   = advect_term(px.edge_grad_x, px.edge_grad_y,
                          px.grad_x_central, px.grad_y_central, sat);
      inf   = fix_mul(px.inflation_map, px.flux, sat);
      crv   = fix_mul(px.curvature_map, px.mean_curvature, sat);
      crv   = fix_mul(crv, px.flux, sat);
      a     = fix_mul(adv_weight, adv, sat);
      b     = fix_mul(inf_weight, inf, sat);
      c     = fix_mul(crv_weight, crv, sat);
      speed = clip32(a - b + c, sat);
      delta = fix_mul(step_size, speed, sat);
      res   = clip32(64'(px.level_value) + delta, sat);
      r.new_level_value = res[31:0];
      r.saturated       = sat;
      return r;
   endfunction

   assign pending_count = pending_levels.size();

   // Track registers, queue predictions and compare result words
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         adv_weight <= '0;
         inf_weight <= '0;
         crv_weight <= '0;
         step_size  <= 32'sd65536;
         pending_levels.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ADVECTION: adv_weight <= csr_wdata;
               CSR_INFLATION: inf_weight <= csr_wdata;
               CSR_CURVATURE: crv_weight <= csr_wdata;
               CSR_TIME_STEP: step_size  <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) pending_levels.push_back(update_pixel(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_levels.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                        rsp_data.new_level_value, rsp_data.saturated);
               fail_count <= fail_count + 1;
            end else begin
               want = pending_levels.pop_front();
               if (want.new_level_value !== rsp_data.new_level_value) begin
                  $display("%0t: new_level_value expected %h actual %h", $time,
                           want.new_level_value, rsp_data.new_level_value);
                  fail_count <= fail_count + 1;
               end
               if (want.saturated !== rsp_data.saturated) begin
                  $display("%0t: saturated expected %b actual %b", $time,
                           want.saturated, rsp_data.saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### tb/sv/tb_levelset_speed_update.sv
// Testbench top for the level set update block: clock, reset, stimulus and verdict
module tb_levelset_speed_update;
   import lsu_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending_count;
   bit          calm;

   levelset_speed_update dut (.*);

   levelset_speed_update_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm      = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result side at random unless in a calm stretch
   always @(posedge clock) rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 28);

   // Field value biased towards extremes and small magnitudes
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3, 4, 5: return $urandom_range(32'h000FFFFF) - 32'h00080000;
         default: return $urandom;
      endcase
   endfunction

   // Register value: small weights mostly, extremes now and then
   function automatic logic [31:0] pick_weight();
      case ($urandom_range(7))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'h0;
         3: return $urandom;
         default: return $urandom_range(32'h0003FFFF) - 32'h00020000;
      endcase
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Wait for the pipe to drain, then let it settle
   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Drop the input side, drain, then write all four registers
   task automatic set_regs(input logic [31:0] a, input logic [31:0] b,
                           input logic [31:0] c, input logic [31:0] t);
      req_valid <= 1'b0;
      drain();
      write_reg(CSR_ADVECTION, a);
      write_reg(CSR_INFLATION, b);
      write_reg(CSR_CURVATURE, c);
      write_reg(CSR_TIME_STEP, t);
   endtask

   // Offer one pixel word, with an optional gap first, and hold until taken
   task automatic send_pixel(input req_type px);
      if (!calm && $urandom_range(99) < 28) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_fill(input logic [31:0] v, input bit zero_grad);
      req_type px;
      px = {9{v}};
      if (zero_grad) begin
         px.grad_x_central = '0;
         px.grad_y_central = '0;
      end
      send_pixel(px);
   endtask

   function automatic req_type pick_pixel();
      req_type px;
      px.level_value    = pick_word();
      px.grad_x_central = pick_word();
      px.grad_y_central = pick_word();
      px.edge_grad_x    = pick_word();
      px.edge_grad_y    = pick_word();
      px.inflation_map  = pick_word();
      px.flux           = pick_word();
      px.curvature_map  = pick_word();
      px.mean_curvature = pick_word();
      if ($urandom_range(9) == 0) begin
         px.grad_x_central = '0;
         px.grad_y_central = '0;
      end
      return px;
   endfunction

   initial begin
      req_type px;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset registers, then unit weights, then extremes
      send_fill(32'h00010000, 1'b0);
      send_fill(32'h7FFFFFFF, 1'b0);
      set_regs(32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
      send_fill(32'h0, 1'b0);
      send_fill(32'h00010000, 1'b0);
      send_fill(32'h00010000, 1'b1);
      send_fill(32'h7FFFFFFF, 1'b0);
      send_fill(32'h80000000, 1'b0);
      send_fill(32'h80000000, 1'b1);
      send_fill(32'hFFFFFFFF, 1'b0);
      // Saturation that a later stage brings back into range
      px = {9{32'h0}};
      px.inflation_map = 32'h7FFFFFFF;
      px.flux = 32'h7FFFFFFF;
      send_pixel(px);
      // Gradients of opposite sign so the dot product cancels
      px = {9{32'h0}};
      px.grad_x_central = 32'h80000000;
      px.grad_y_central = 32'h7FFFFFFF;
      px.edge_grad_x = 32'h80000000;
      px.edge_grad_y = 32'h80000000;
      send_pixel(px);
      px.edge_grad_y = 32'h7FFFFFFF;
      send_pixel(px);
      set_regs(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
      send_fill(32'h00010000, 1'b0);
      send_fill(32'h7FFFFFFF, 1'b0);
      send_fill(32'h80000000, 1'b0);
      send_fill(32'h00000001, 1'b1);
      set_regs(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      send_fill(32'hFFFF0000, 1'b0);
      send_fill(32'h7FFFFFFF, 1'b0);
      send_fill(32'h00000001, 1'b0);
      set_regs(32'h0, 32'h0, 32'h0, 32'h0);
      send_fill(32'h12345678, 1'b0);

      // Random phases, each under fresh registers; one phase runs with no idling
      for (int ph = 0; ph < 8; ph++) begin
         req_valid <= 1'b0;
         set_regs(pick_weight(), pick_weight(), pick_weight(), pick_weight());
         calm = (ph == 3);
         for (int i = 0; i < 240; i++) send_pixel(pick_pixel());
         calm = 1'b0;
      end
      req_valid <= 1'b0;
      drain();

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Give up after a generous time
   initial begin
      #20000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
